// ===== sv/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 cipher package
// Shared constants, request and result types and sequencer states.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int MAX_KEY_BYTES = 256;
    localparam int BYTE_W        = 8;
    localparam int ADDR_W        = $clog2(TABLE_SIZE);
    localparam int KEY_CNT_W     = $clog2(MAX_KEY_BYTES + 1);

    typedef enum logic {
        KIND_KEY  = 1'b0,
        KIND_DATA = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  value;
        logic               key_last;
    } t_req;

    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  out_byte;
    } t_res;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_RD_K,
        ST_XOR
    } t_state;

endpackage

// ===== sv/rc4_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// Streaming RC4: key bytes are stored, the marked last key byte runs the key
// schedule, and data bytes come back XORed with the keystream.
// ----------------------------------------------------------------------------
// After reset the unit fills its permutation table with the identity before the
// first request is accepted. Key bytes without the last mark are taken one per
// cycle. A key byte marked last occupies the unit while it reloads the identity
// and runs the mixing pass, which reads and swaps two table entries per index.
// A data byte takes the same swap, a keystream read and the XOR state, where
// back-pressure can hold it, before the next request is accepted. This order
// follows from the permutation memory's single registered read port, shared by
// every table read and swap. The result waits in an output register, so the
// core returns to idle while a finished byte still waits on the downstream side.
module rc4_stream_cipher_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] value
    input  logic [0:0] s_axis_tuser,   // [0] kind
    input  logic       s_axis_tlast,   // key_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] out_byte
);
    import rc4_pkg::*;

    t_req              req;
    t_res              res;
    logic              res_ready;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;

    assign req.kind     = t_kind'(s_axis_tuser[0]);
    assign req.value    = s_axis_tdata;
    assign req.key_last = s_axis_tlast;

    assign res_ready = !r_out_valid || m_axis_tready;

    rc4_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_byte <= res.out_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;

endmodule

// ===== sv/rc4_core.sv =====
// ----------------------------------------------------------------------------
// RC4 core sequencer
// Holds the permutation table and the key store in memories with one write and
// one registered read port each, and runs the identity fill, the key schedule
// and the generator step in one state sequence.
// ----------------------------------------------------------------------------
module rc4_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  rc4_pkg::t_req  i_req,
    output rc4_pkg::t_res  o_res,
    input  logic           i_res_ready
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] r_perm [TABLE_SIZE];
    logic [BYTE_W-1:0] r_keys [MAX_KEY_BYTES];

    t_state               r_state, n_state;
    logic                 r_sched, n_sched;
    logic [ADDR_W-1:0]    r_i, n_i;
    logic [ADDR_W-1:0]    r_j, n_j;
    logic [ADDR_W-1:0]    r_kpos, n_kpos;
    logic [KEY_CNT_W-1:0] r_key_count, n_key_count;
    logic [KEY_CNT_W-1:0] r_key_length, n_key_length;
    logic [BYTE_W-1:0]    r_value, n_value;
    logic [BYTE_W-1:0]    r_si, n_si;
    logic [BYTE_W-1:0]    r_sj, n_sj;

    logic [BYTE_W-1:0]    r_s_rdata;
    logic [BYTE_W-1:0]    r_k_rdata;
    logic                 s_we;
    logic [ADDR_W-1:0]    s_waddr;
    logic [BYTE_W-1:0]    s_wdata;
    logic [ADDR_W-1:0]    s_raddr;
    logic                 k_we;
    logic [ADDR_W-1:0]    k_waddr;
    logic [BYTE_W-1:0]    key_byte;
    logic [KEY_CNT_W-1:0] count_after;
    logic [KEY_CNT_W-1:0] kpos_next;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_perm[s_waddr] <= s_wdata;
        end
        r_s_rdata <= r_perm[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            r_keys[k_waddr] <= i_req.value;
        end
        r_k_rdata <= r_keys[r_kpos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_sched      <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_kpos       <= '0;
            r_key_count  <= '0;
            r_key_length <= '0;
        end else begin
            r_state      <= n_state;
            r_sched      <= n_sched;
            r_i          <= n_i;
            r_j          <= n_j;
            r_kpos       <= n_kpos;
            r_key_count  <= n_key_count;
            r_key_length <= n_key_length;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_si    <= n_si;
        r_sj    <= n_sj;
    end

    // An empty key acts as all zero bytes.
    assign key_byte  = (r_key_length != '0) ? r_k_rdata : '0;
    assign kpos_next = {1'b0, r_kpos} + KEY_CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_sched      = r_sched;
        n_i          = r_i;
        n_j          = r_j;
        n_kpos       = r_kpos;
        n_key_count  = r_key_count;
        n_key_length = r_key_length;
        n_value      = r_value;
        n_si         = r_si;
        n_sj         = r_sj;
        s_we         = 1'b0;
        s_waddr      = r_i;
        s_wdata      = r_s_rdata;
        s_raddr      = r_i;
        k_we         = 1'b0;
        k_waddr      = r_key_count[ADDR_W-1:0];
        count_after  = r_key_count;
        o_req_ready  = 1'b0;
        o_res.valid    = 1'b0;
        o_res.out_byte = r_value ^ r_s_rdata;

        case (r_state)
            ST_FILL: begin
                s_we    = 1'b1;
                s_wdata = BYTE_W'(r_i);
                n_i     = r_i + ADDR_W'(1);
                if (r_i == ADDR_W'(TABLE_SIZE - 1)) begin
                    n_j    = '0;
                    n_kpos = '0;
                    n_state = r_sched ? ST_RD_I : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req.kind == KIND_KEY) begin
                        if (r_key_count < KEY_CNT_W'(MAX_KEY_BYTES)) begin
                            k_we        = 1'b1;
                            count_after = r_key_count + KEY_CNT_W'(1);
                        end
                        n_key_count = count_after;
                        if (i_req.key_last) begin
                            n_key_length = count_after;
                            n_key_count  = '0;
                            n_sched      = 1'b1;
                            n_i          = '0;
                            n_state      = ST_FILL;
                        end
                    end else begin
                        n_value = i_req.value;
                        n_sched = 1'b0;
                        n_i     = r_i + ADDR_W'(1);
                        n_state = ST_RD_I;
                    end
                end
            end
            ST_RD_I: begin
                s_raddr = r_i;
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                n_si    = r_s_rdata;
                n_j     = r_j + r_s_rdata + (r_sched ? key_byte : '0);
                s_raddr = n_j;
                n_state = ST_WR_I;
            end
            ST_WR_I: begin
                s_we    = 1'b1;
                s_waddr = r_i;
                s_wdata = r_s_rdata;
                n_sj    = r_s_rdata;
                n_state = ST_WR_J;
            end
            ST_WR_J: begin
                s_we    = 1'b1;
                s_waddr = r_j;
                s_wdata = r_si;
                if (r_sched) begin
                    n_i    = r_i + ADDR_W'(1);
                    n_kpos = (kpos_next >= r_key_length) ? '0 : kpos_next[ADDR_W-1:0];
                    if (r_i == ADDR_W'(TABLE_SIZE - 1)) begin
                        n_j     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RD_I;
                    end
                end else begin
                    n_state = ST_RD_K;
                end
            end
            ST_RD_K: begin
                s_raddr = r_si + r_sj;
                n_state = ST_XOR;
            end
            ST_XOR: begin
                // Keep the keystream address so the read data stays put while stalled.
                s_raddr     = r_si + r_sj;
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== bench/rc4_stream_cipher_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 stream cipher unit testbench
// Streams key and data requests into the unit, then checks every returned
// byte in order against a cycle-free RC4 predictor. Sender bursts, receiver
// stalls, long back-pressure and full drains are mixed into the run.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit_test;
    import rc4_pkg::*;

    localparam int ITEMS_TARGET = 1450;
    // The slowest correct run stays far below this: a few dozen key schedules, data
    // bytes plus stalls and gaps, the long holds.
    localparam int LIMIT_CYCLES = 600_000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic        drain;
        t_kind       kind;
        logic [7:0]  value;
        logic        last;
    } t_pending_req;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;    // [7:0] value
    logic [0:0] s_axis_tuser  = '0;    // [0] kind
    logic       s_axis_tlast  = 1'b0;  // key_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_byte

    rc4_stream_cipher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state
    logic [7:0] perm [TABLE_SIZE];
    logic [7:0] key_bytes [TABLE_SIZE];
    logic [8:0] key_fill;
    logic [8:0] sched_len;
    logic [7:0] gen_i;
    logic [7:0] gen_j;

    t_pending_req req_q [$];
    logic [7:0]   cipher_out_q [$];

    int  items_total     = 0;
    int  live_items      = 0;
    int  items_accepted  = 0;
    int  results_seen    = 0;
    int  error_count     = 0;
    int  keys_scheduled  = 0;
    int  keys_dropped    = 0;
    int  drains_done     = 0;
    int  long_holds      = 0;
    int  cycle_count     = 0;
    logic req_taken      = 1'b0;

    // Sender and receiver pacing
    int  burst_left   = 1;
    int  gap_left     = 0;
    int  long_hold    = 0;
    int  next_hold_at = 60;
    int  stall_pct    = 0;
    int  stall_timer  = 0;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic load_identity();
        for (int k = 0; k < TABLE_SIZE; k++) begin
            perm[k] = k[7:0];
        end
    endtask

    task automatic mix_key_schedule();
        logic [7:0] acc;
        logic [7:0] kb;
        logic [7:0] tmp;
        int         kpos;
        acc  = '0;
        kpos = 0;
        load_identity();
        for (int n = 0; n < TABLE_SIZE; n++) begin
            kb = (sched_len != 0) ? key_bytes[kpos] : 8'h00;
            acc = acc + kb + perm[n];
            tmp = perm[n];
            perm[n] = perm[acc];
            perm[acc] = tmp;
            kpos++;
            if (kpos >= sched_len) kpos = 0;
        end
        gen_i = '0;
        gen_j = '0;
    endtask

    task automatic absorb_key_byte(input logic [7:0] v, input logic mark);
        if (key_fill < MAX_KEY_BYTES) begin
            key_bytes[key_fill[7:0]] = v;
            key_fill = key_fill + 9'd1;
        end else begin
            keys_dropped++;
        end
        if (mark) begin
            sched_len = key_fill;
            mix_key_schedule();
            key_fill = '0;
            keys_scheduled++;
        end
    endtask

    function automatic logic [7:0] next_cipher_byte(input logic [7:0] din);
        logic [7:0] tmp;
        logic [7:0] sel;
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + perm[gen_i];
        tmp = perm[gen_i];
        perm[gen_i] = perm[gen_j];
        perm[gen_j] = tmp;
        sel = perm[gen_i] + perm[gen_j];
        return din ^ perm[sel];
    endfunction

    task automatic push_req(input t_kind k, input logic [7:0] v, input logic mark);
        t_pending_req r;
        r.drain = 1'b0;
        r.kind  = k;
        r.value = v;
        r.last  = mark;
        req_q.push_back(r);
        items_total++;
        live_items++;
    endtask

    task automatic push_drain();
        t_pending_req r;
        r.drain = 1'b1;
        r.kind  = KIND_KEY;
        r.value = '0;
        r.last  = 1'b0;
        req_q.push_back(r);
    endtask

    task automatic push_key(input int len);
        for (int k = 0; k < len; k++) begin
            push_req(KIND_KEY, 8'($urandom_range(0, 255)), k == len - 1);
        end
        // Bytes past the store depth are dropped by the unit.
        if (len > MAX_KEY_BYTES) live_items -= len - MAX_KEY_BYTES;
    endtask

    task automatic push_data_run(input int len);
        for (int k = 0; k < len; k++) begin
            push_req(KIND_DATA, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    // Request driver: one request per handshake, paced in bursts and gaps.
    always @(negedge i_clk) begin : req_driver
        t_pending_req nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !req_taken) begin
            // The offered request has not been taken yet, so it stays put.
        end else if (gap_left != 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (req_q.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (req_q[0].drain) begin
            s_axis_tvalid <= 1'b0;
            if (cipher_out_q.size() == 0) begin
                req_q.delete(0);
                drains_done++;
            end
        end else begin
            nxt = req_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= nxt.value;
            s_axis_tuser  <= nxt.kind;
            s_axis_tlast  <= nxt.last;
            if (burst_left > 1) begin
                burst_left <= burst_left - 1;
            end else if ($urandom_range(0, 4) == 0) begin
                burst_left <= $urandom_range(50, 200);
                gap_left   <= 0;
            end else begin
                burst_left <= $urandom_range(1, 20);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
    end

    // Receiver: a drifting stall rate, plus a long hold now and then.
    always @(negedge i_clk) begin : result_sink
        if (long_hold != 0) begin
            m_axis_tready <= 1'b0;
            long_hold <= long_hold - 1;
        end else if (i_rst_n && results_seen >= next_hold_at) begin
            m_axis_tready <= 1'b0;
            long_hold     <= HOLD_CYCLES;
            next_hold_at  <= next_hold_at + 500;
            long_holds++;
        end else begin
            m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
        end
        if (stall_timer == 0) begin
            case ($urandom_range(0, 3))
                0: begin stall_pct <= 0;  end
                1: begin stall_pct <= 25; end
                2: begin stall_pct <= 60; end
                default: begin stall_pct <= 90; end
            endcase
            stall_timer <= $urandom_range(64, 400);
        end else begin
            stall_timer <= stall_timer - 1;
        end
    end

    // Accepted requests feed the predictor; results are checked in order.
    always @(posedge i_clk) begin : stream_monitor
        logic [7:0] want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                items_accepted <= items_accepted + 1;
                if (s_axis_tuser[0] == KIND_DATA) begin
                    cipher_out_q.push_back(next_cipher_byte(s_axis_tdata));
                end else begin
                    absorb_key_byte(s_axis_tdata, s_axis_tlast);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                if (cipher_out_q.size() == 0) begin
                    flag_error($sformatf("unexpected result byte 0x%02h", m_axis_tdata));
                end else begin
                    want = cipher_out_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        flag_error($sformatf("result %0d: out_byte 0x%02h, expected 0x%02h",
                                             results_seen, m_axis_tdata, want));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int seq;
        int r;
        load_identity();
        for (int k = 0; k < TABLE_SIZE; k++) key_bytes[k] = '0;
        key_fill  = '0;
        sched_len = '0;
        gen_i     = '0;
        gen_j     = '0;

        // Directed: identity table before any key, a one-byte key, a short key,
        // the last mark on data bytes, and a key that starts after a full drain.
        push_req(KIND_DATA, 8'h00, 1'b0);
        push_req(KIND_DATA, 8'hFF, 1'b1);
        push_req(KIND_DATA, 8'hA5, 1'b0);
        push_req(KIND_KEY,  8'hFF, 1'b1);
        push_req(KIND_DATA, 8'h00, 1'b0);
        push_req(KIND_DATA, 8'hFF, 1'b0);
        push_req(KIND_DATA, 8'h3C, 1'b1);
        push_req(KIND_DATA, 8'h5A, 1'b0);
        push_req(KIND_KEY,  8'h00, 1'b0);
        push_req(KIND_KEY,  8'h80, 1'b0);
        push_req(KIND_KEY,  8'h7F, 1'b0);
        push_req(KIND_KEY,  8'h01, 1'b1);
        push_req(KIND_DATA, 8'h00, 1'b0);
        push_req(KIND_DATA, 8'hFF, 1'b1);
        push_req(KIND_DATA, 8'h81, 1'b0);
        push_req(KIND_DATA, 8'h7E, 1'b0);
        push_drain();
        push_req(KIND_KEY,  8'h00, 1'b1);
        push_req(KIND_DATA, 8'hFF, 1'b0);
        push_req(KIND_DATA, 8'h00, 1'b0);

        // Random: mostly a key followed by a data run, with stray key bytes
        // that fold into the next key, one full-depth key and one overflow.
        seq = 0;
        while (live_items < ITEMS_TARGET) begin
            seq++;
            r = $urandom_range(0, 99);
            if (seq == 6) begin
                push_key(MAX_KEY_BYTES);
            end else if (seq == 17) begin
                push_key(MAX_KEY_BYTES + $urandom_range(1, 40));
            end else if (r < 3) begin
                push_key($urandom_range(100, MAX_KEY_BYTES));
            end else if (r < 78) begin
                push_key($urandom_range(1, 16));
            end else if (r < 88) begin
                repeat ($urandom_range(1, 4)) begin
                    push_req(KIND_KEY, 8'($urandom_range(0, 255)), 1'b0);
                end
            end
            push_data_run($urandom_range(1, 40));
            if (seq % 12 == 0) push_drain();
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(items_accepted == items_total && cipher_out_q.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (cipher_out_q.size() != 0) begin
            flag_error($sformatf("%0d result bytes never arrived", cipher_out_q.size()));
        end

        $display("Ran %0d key schedules (%0d key bytes beyond the store dropped), %0d %s",
                 keys_scheduled, keys_dropped, results_seen, "bytes ciphered");
        $display("Receiver held off %0d times, sender drained the pipe %0d times, %0d cycles",
                 long_holds, drains_done, cycle_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
